FILE: rtl/dtd_pkg.sv
`timescale 1ns / 1ps

package dtd_pkg;

    localparam int unsigned SLOTS_DEF = 8;

    localparam int unsigned OP_W   = 3;
    localparam int unsigned ID_W   = 8;
    localparam int unsigned CNT_W  = 16;
    localparam int unsigned STAT_W = 2;

    localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_W-1:0] OP_SET    = 3'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OP_W-1:0] OP_CHANGE = 3'd3;
    localparam logic [OP_W-1:0] OP_POP    = 3'd4;

    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_IGNORED = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [ID_W-1:0]  task_id;
        logic [CNT_W-1:0] delay_ticks;
    } cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]   popped_id;
        logic [STAT_W-1:0] status;
    } res_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_PLACE,
        S_DONE
    } state_t;

    // Shift controls for both rings; the tail values are the processed heads.
    typedef struct packed {
        logic             d_shift;
        logic [ID_W-1:0]  d_tail_id;
        logic [CNT_W-1:0] d_tail_cnt;
        logic             r_shift;
        logic [ID_W-1:0]  r_tail_id;
    } ring_ctl_t;

endpackage

FILE: rtl/dtd_slot_cell.sv
`timescale 1ns / 1ps

module dtd_slot_cell
    import dtd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift,
    input  logic [ID_W-1:0]  nxt_id,
    input  logic [CNT_W-1:0] nxt_cnt,
    output logic [ID_W-1:0]  id,
    output logic [CNT_W-1:0] cnt
);

    logic [ID_W-1:0]  id_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [ID_W-1:0]  id_next;
    logic [CNT_W-1:0] cnt_next;

    always_comb
    begin
        id_next  = id_reg;
        cnt_next = cnt_reg;
        if (shift)
        begin
            id_next  = nxt_id;
            cnt_next = nxt_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            id_reg  <= id_next;
            cnt_reg <= cnt_next;
        end
    end

    assign id  = id_reg;
    assign cnt = cnt_reg;

endmodule

FILE: rtl/dtd_ready_cell.sv
`timescale 1ns / 1ps

module dtd_ready_cell
    import dtd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            shift,
    input  logic [ID_W-1:0] nxt_id,
    output logic [ID_W-1:0] id,
    output logic            empty
);

    logic [ID_W-1:0] id_reg;
    logic [ID_W-1:0] id_next;

    always_comb
    begin
        id_next = shift ? nxt_id : id_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg <= '0;
        end
        else
        begin
            id_reg <= id_next;
        end
    end

    assign id    = id_reg;
    assign empty = (id_reg == '0);

endmodule

FILE: rtl/dtd_seq.sv
`timescale 1ns / 1ps

module dtd_seq
    import dtd_pkg::*;
#(
    parameter int unsigned SLOTS = SLOTS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  cmd_t             cmd,
    output logic             res_valid,
    input  logic             res_stall,
    output res_t             res,
    input  logic [ID_W-1:0]  d_head_id,
    input  logic [CNT_W-1:0] d_head_cnt,
    input  logic [ID_W-1:0]  r_head_id,
    input  logic             r_head_empty,
    output ring_ctl_t        ctl
);

    localparam int unsigned CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] LAST = CW'(SLOTS);

    state_t           state_reg, state_next;
    logic [OP_W-1:0]  op_reg;
    logic [ID_W-1:0]  id_reg;
    logic [CNT_W-1:0] ticks_reg;
    logic [CW-1:0]    s_cnt_reg, r_cnt_reg;
    logic             dup_reg, free_reg, placed_reg, ign_reg;
    logic [ID_W-1:0]  popped_reg;
    logic             res_valid_reg;
    res_t             res_reg, res_next;

    logic             s_inc, r_inc;
    logic             accept, id_zero_op, bad_op, sweep_end, load;

    assign cmd_stall  = (state_reg != S_IDLE);
    assign accept     = cmd_valid && !cmd_stall;
    assign id_zero_op = (cmd.task_id == '0) &&
                        (cmd.opcode == OP_SET || cmd.opcode == OP_DELETE ||
                         cmd.opcode == OP_CHANGE);
    assign bad_op     = (cmd.opcode > OP_POP);
    assign sweep_end  = (s_cnt_reg == LAST) && (r_cnt_reg == LAST);
    assign load       = (state_reg == S_DONE) && (!res_valid_reg || !res_stall);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (id_zero_op || bad_op) ? S_DONE : S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                if (op_reg == OP_POP)
                begin
                    state_next = S_DONE;
                end
                else if (sweep_end)
                begin
                    state_next = (op_reg == OP_SET && !dup_reg && free_reg) ? S_PLACE
                                                                            : S_DONE;
                end
            end
            S_PLACE:
            begin
                if (s_cnt_reg == LAST)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Ring controls: the head cell is processed and rotated to the tail
    always_comb
    begin
        ctl            = '0;
        ctl.d_tail_id  = d_head_id;
        ctl.d_tail_cnt = d_head_cnt;
        ctl.r_tail_id  = r_head_id;
        s_inc          = 1'b0;
        r_inc          = 1'b0;
        case (state_reg)
            S_SWEEP:
            begin
                case (op_reg)
                    OP_TICK:
                    begin
                        if (s_cnt_reg != LAST)
                        begin
                            if (d_head_cnt != '0)
                            begin
                                ctl.d_shift    = 1'b1;
                                ctl.d_tail_cnt = d_head_cnt - 1'b1;
                                s_inc          = 1'b1;
                            end
                            else if (d_head_id == '0 || r_cnt_reg == LAST)
                            begin
                                // nothing due, or no ready entry left: slot waits
                                ctl.d_shift = 1'b1;
                                s_inc       = 1'b1;
                            end
                            else if (!r_head_empty)
                            begin
                                ctl.r_shift = 1'b1;
                                r_inc       = 1'b1;
                            end
                            else
                            begin
                                // move the due task into the empty ready entry
                                ctl.r_shift    = 1'b1;
                                ctl.r_tail_id  = d_head_id;
                                ctl.d_shift    = 1'b1;
                                ctl.d_tail_id  = '0;
                                ctl.d_tail_cnt = '0;
                                s_inc          = 1'b1;
                                r_inc          = 1'b1;
                            end
                        end
                        else if (r_cnt_reg != LAST)
                        begin
                            ctl.r_shift = 1'b1;
                            r_inc       = 1'b1;
                        end
                    end
                    OP_SET, OP_DELETE, OP_CHANGE:
                    begin
                        if (s_cnt_reg != LAST)
                        begin
                            ctl.d_shift = 1'b1;
                            ctl.r_shift = 1'b1;
                            s_inc       = 1'b1;
                            r_inc       = 1'b1;
                            if (op_reg == OP_DELETE && d_head_id == id_reg)
                            begin
                                ctl.d_tail_id  = '0;
                                ctl.d_tail_cnt = '0;
                            end
                            if (op_reg == OP_DELETE && r_head_id == id_reg)
                            begin
                                ctl.r_tail_id = '0;
                            end
                            if (op_reg == OP_CHANGE && d_head_id == id_reg)
                            begin
                                ctl.d_tail_cnt = ticks_reg;
                            end
                        end
                    end
                    OP_POP:
                    begin
                        ctl.r_shift   = 1'b1;
                        ctl.r_tail_id = '0;
                    end
                    default:
                    begin
                        ctl.r_shift = 1'b0;
                    end
                endcase
            end
            S_PLACE:
            begin
                if (s_cnt_reg != LAST)
                begin
                    ctl.d_shift = 1'b1;
                    s_inc       = 1'b1;
                    if (!placed_reg && d_head_id == '0)
                    begin
                        ctl.d_tail_id  = id_reg;
                        ctl.d_tail_cnt = ticks_reg;
                    end
                end
            end
            default:
            begin
                ctl.d_shift = 1'b0;
            end
        endcase
    end

    // Result
    always_comb
    begin
        res_next.popped_id = (op_reg == OP_POP) ? popped_reg : '0;
        if (ign_reg || (op_reg == OP_SET && dup_reg))
        begin
            res_next.status = ST_IGNORED;
        end
        else if (op_reg == OP_SET && !free_reg)
        begin
            res_next.status = ST_FULL;
        end
        else
        begin
            res_next.status = ST_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            s_cnt_reg     <= '0;
            r_cnt_reg     <= '0;
            dup_reg       <= 1'b0;
            free_reg      <= 1'b0;
            placed_reg    <= 1'b0;
            ign_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                s_cnt_reg  <= '0;
                r_cnt_reg  <= '0;
                dup_reg    <= 1'b0;
                free_reg   <= 1'b0;
                placed_reg <= 1'b0;
                ign_reg    <= id_zero_op;
            end
            else if (state_reg == S_SWEEP && state_next == S_PLACE)
            begin
                s_cnt_reg <= '0;
            end
            else
            begin
                s_cnt_reg <= s_cnt_reg + CW'(s_inc);
                r_cnt_reg <= r_cnt_reg + CW'(r_inc);
            end
            if (state_reg == S_SWEEP && op_reg == OP_SET && s_cnt_reg != LAST)
            begin
                if (d_head_id == id_reg || r_head_id == id_reg)
                begin
                    dup_reg <= 1'b1;
                end
                if (d_head_id == '0)
                begin
                    free_reg <= 1'b1;
                end
            end
            if (state_reg == S_PLACE && s_cnt_reg != LAST && d_head_id == '0)
            begin
                placed_reg <= 1'b1;
            end
            if (load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= cmd.opcode;
            id_reg    <= cmd.task_id;
            ticks_reg <= cmd.delay_ticks;
        end
        if (state_reg == S_SWEEP && op_reg == OP_POP)
        begin
            popped_reg <= r_head_id;
        end
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (s_cnt_reg <= LAST) && (r_cnt_reg <= LAST))
        else $error("sweep counter beyond slot count");

    a_shift_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.d_shift || ctl.r_shift) |-> (state_reg == S_SWEEP || state_reg == S_PLACE))
        else $error("ring shifted while not sweeping");

    a_place_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PLACE && s_cnt_reg == LAST) |-> placed_reg)
        else $error("free slot seen but task not placed");

    a_res_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside completion");

    a_tick_full_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP && op_reg == OP_TICK && state_next == S_DONE)
        |-> sweep_end)
        else $error("tick finished before both rings came around");

endmodule

FILE: rtl/delayed_task_dispatcher.sv
`timescale 1ns / 1ps
// Sequence from accept to res_valid: pop takes the ready head and finishes; delete, change
// delay and a set that is ignored or finds no free slot sweep both rings once; a placed set
// then makes a placement pass over the slots; tick sweeps both rings, one cell at a time;
// zero id or undefined opcode goes straight to the result. Throughput: one request at a time;
// cmd_stall drops as res_valid rises, even while that result still waits in the output register.
// Reset (rst_n, async, active low) clears every slot, every ready entry and control state.
module delayed_task_dispatcher
    import dtd_pkg::*;
#(
    parameter int unsigned SLOTS = SLOTS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    logic [ID_W-1:0]  slot_id  [SLOTS];
    logic [CNT_W-1:0] slot_cnt [SLOTS];
    logic [ID_W-1:0]  rdy_id   [SLOTS];
    logic             rdy_empty[SLOTS];
    ring_ctl_t        ctl;

    genvar i;
    generate
        for (i = 0; i < SLOTS; i++)
        begin : g_cell
            if (i == SLOTS - 1)
            begin : g_tail
                dtd_slot_cell u_slot (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .shift   (ctl.d_shift),
                    .nxt_id  (ctl.d_tail_id),
                    .nxt_cnt (ctl.d_tail_cnt),
                    .id      (slot_id[i]),
                    .cnt     (slot_cnt[i])
                );
                dtd_ready_cell u_rdy (
                    .clk    (clk),
                    .rst_n  (rst_n),
                    .shift  (ctl.r_shift),
                    .nxt_id (ctl.r_tail_id),
                    .id     (rdy_id[i]),
                    .empty  (rdy_empty[i])
                );
            end
            else
            begin : g_body
                dtd_slot_cell u_slot (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .shift   (ctl.d_shift),
                    .nxt_id  (slot_id[i+1]),
                    .nxt_cnt (slot_cnt[i+1]),
                    .id      (slot_id[i]),
                    .cnt     (slot_cnt[i])
                );
                dtd_ready_cell u_rdy (
                    .clk    (clk),
                    .rst_n  (rst_n),
                    .shift  (ctl.r_shift),
                    .nxt_id (rdy_id[i+1]),
                    .id     (rdy_id[i]),
                    .empty  (rdy_empty[i])
                );
            end
        end
    endgenerate

    dtd_seq #(
        .SLOTS (SLOTS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd          (cmd),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .res          (res),
        .d_head_id    (slot_id[0]),
        .d_head_cnt   (slot_cnt[0]),
        .r_head_id    (rdy_id[0]),
        .r_head_empty (rdy_empty[0]),
        .ctl          (ctl)
    );

endmodule
